### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define AMGR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define AMGR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/amgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amgr_pkg;

    localparam int MAX_ALTS  = 4;
    localparam int SLOTS_MAX = 4;
    localparam int NUM_LANES = (MAX_ALTS < SLOTS_MAX) ? MAX_ALTS : SLOTS_MAX;

    localparam int BASE_W = 8;
    localparam int IDX_W  = 3;
    localparam int GT_W   = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // s_tdata field offsets
    localparam int OFS_REF_BASE   = 0;
    localparam int OFS_REF_SINGLE = 8;
    localparam int OFS_ALT_BASES  = 9;
    localparam int OFS_ALT_MASK   = 41;
    localparam int OFS_EXP_REF    = 45;
    localparam int OFS_EXP_ALT    = 53;
    localparam int OFS_GT_CHAR    = 61;
    localparam int S_USED_W       = 69;

    localparam logic [BASE_W-1:0] BASE_A    = 8'h41;
    localparam logic [BASE_W-1:0] BASE_C    = 8'h43;
    localparam logic [BASE_W-1:0] BASE_G    = 8'h47;
    localparam logic [BASE_W-1:0] BASE_T    = 8'h54;
    localparam logic [BASE_W-1:0] CHAR_ZERO = 8'h30;

    localparam logic CMD_VARIANT = 1'b0;
    localparam logic CMD_SAMPLE  = 1'b1;

    localparam logic [GT_W-1:0] GT_REF     = 2'd0;
    localparam logic [GT_W-1:0] GT_ALT     = 2'd1;
    localparam logic [GT_W-1:0] GT_MISSING = 2'd3;

    typedef struct packed {
        logic hit_ref;
        logic hit_alt;
        logic hit_ref_flip;
        logic hit_alt_flip;
        logic acgt;
    } amgr_lane_flags_t;

    typedef struct packed {
        logic             usable;
        logic [IDX_W-1:0] ref_idx;
        logic [IDX_W-1:0] alt_idx;
    } amgr_match_t;

    typedef struct packed {
        logic             kind;
        logic [GT_W-1:0]  gcode;
        logic             usable;
        logic [IDX_W-1:0] alt_idx;
        logic [IDX_W-1:0] ref_idx;
    } amgr_result_t;

    function automatic logic [BASE_W-1:0] complement_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        case (b)
            BASE_A:  r = BASE_T;
            BASE_T:  r = BASE_A;
            BASE_C:  r = BASE_G;
            BASE_G:  r = BASE_C;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic is_acgt(input logic [BASE_W-1:0] b);
        return (b == BASE_A) || (b == BASE_C) || (b == BASE_G) || (b == BASE_T);
    endfunction

endpackage

`default_nettype wire

### sv/amgr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module amgr_lane
    import amgr_pkg::*;
(
    input  wire logic [BASE_W-1:0] alt_base,
    input  wire logic              alt_single,
    input  wire logic [BASE_W-1:0] expected_ref,
    input  wire logic [BASE_W-1:0] expected_alt,
    output amgr_lane_flags_t       flags
);

    logic [BASE_W-1:0] alt_flip;

    assign alt_flip = complement_base(alt_base);

    // a slot without its single-char mask bit never matches
    always_comb
    begin
        flags.hit_ref      = alt_single && (alt_base == expected_ref);
        flags.hit_alt      = alt_single && (alt_base == expected_alt);
        flags.hit_ref_flip = alt_single && (alt_flip == expected_ref);
        flags.hit_alt_flip = alt_single && (alt_flip == expected_alt);
        flags.acgt         = alt_single && is_acgt(alt_base);
    end

endmodule

`default_nettype wire

### sv/amgr_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module amgr_merge
    import amgr_pkg::*;
(
    input  wire logic              prophage_mode,
    input  wire logic [BASE_W-1:0] ref_base,
    input  wire logic              ref_is_single,
    input  wire logic [BASE_W-1:0] expected_ref,
    input  wire logic [BASE_W-1:0] expected_alt,
    input  wire amgr_lane_flags_t  lane_flags [NUM_LANES],
    output amgr_match_t            match
);

    logic [BASE_W-1:0] ref_flip;
    logic              flip;

    assign ref_flip = complement_base(ref_base);
    assign flip     = (ref_flip == expected_ref) || (ref_flip == expected_alt);

    // slots are scanned in order; the first hit on a still open allele wins
    always_comb
    begin
        logic             r_found;
        logic             a_found;
        logic [IDX_W-1:0] r_idx;
        logic [IDX_W-1:0] a_idx;
        logic             hr;
        logic             ha;

        r_found = 1'b0;
        a_found = 1'b0;
        r_idx   = '0;
        a_idx   = '0;
        hr      = 1'b0;
        ha      = 1'b0;

        if (ref_is_single)
        begin
            if (prophage_mode)
            begin
                if (ref_base == expected_ref)
                begin
                    r_found = 1'b1;
                    for (int k = 0; k < NUM_LANES; k++)
                    begin
                        if (!a_found && lane_flags[k].acgt)
                        begin
                            a_found = 1'b1;
                            a_idx   = IDX_W'(k + 1);
                        end
                    end
                end
            end
            else
            begin
                if ((ref_base == expected_ref) || (ref_flip == expected_ref))
                    r_found = 1'b1;
                else if ((ref_base == expected_alt) || (ref_flip == expected_alt))
                    a_found = 1'b1;

                if (r_found || a_found)
                begin
                    for (int k = 0; k < NUM_LANES; k++)
                    begin
                        hr = flip ? lane_flags[k].hit_ref_flip : lane_flags[k].hit_ref;
                        ha = flip ? lane_flags[k].hit_alt_flip : lane_flags[k].hit_alt;
                        if (hr && !r_found)
                        begin
                            r_found = 1'b1;
                            r_idx   = IDX_W'(k + 1);
                        end
                        else if (ha && !a_found)
                        begin
                            a_found = 1'b1;
                            a_idx   = IDX_W'(k + 1);
                        end
                    end
                end
            end
        end

        match.usable  = r_found && a_found;
        match.ref_idx = (r_found && a_found) ? r_idx : '0;
        match.alt_idx = (r_found && a_found) ? a_idx : '0;
    end

endmodule

`default_nettype wire

### sv/amgr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module amgr_out_buf
    import amgr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_fire,
    input  wire amgr_result_t in_result,
    output logic        in_ready,
    output logic        out_valid,
    output amgr_result_t out_result,
    input  wire logic   out_ready
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    amgr_result_t out_data_reg, out_data_next;
    amgr_result_t skid_data_reg, skid_data_next;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || in_fire;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_result;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `AMGR_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg,
        "skid item without output item")
    `AMGR_ASSERT(a_stall_fills_skid, (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg,
        "stalled item lost")
    `AMGR_ASSERT(a_drain_skid, (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg),
        "skid not moved to output")

endmodule

`default_nettype wire

### sv/allele_match_genotype_recoder_top.sv
// A two-entry output buffer registers results and keeps s_tready registered.
// Throughput: one item per cycle unless m_* stalls; lane compares, merge and
// genotype coding are combinational.
// Reset (rst_n low, async): output buffer empty, held indices 0, no usable
// variant, prophage_mode 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module allele_match_genotype_recoder_top
    import amgr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // ref_base, ref_is_single, alt_bases, alt_single_mask, expected_ref,
    // expected_alt, genotype_char, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // ref_allele_index, alt_allele_index, usable, genotype_code, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // result_kind
    output logic                      m_tuser
);

    logic                prophage_mode_reg;
    logic                held_usable_reg, held_usable_next;
    logic [IDX_W-1:0]    held_ref_reg, held_ref_next;
    logic [IDX_W-1:0]    held_alt_reg, held_alt_next;

    logic                in_fire;
    logic [BASE_W-1:0]   ref_base;
    logic                ref_is_single;
    logic [BASE_W*SLOTS_MAX-1:0] alt_bases;
    logic [SLOTS_MAX-1:0] alt_single_mask;
    logic [BASE_W-1:0]   expected_ref;
    logic [BASE_W-1:0]   expected_alt;
    logic [BASE_W-1:0]   genotype_char;
    logic [BASE_W-1:0]   gt_num;
    logic [GT_W-1:0]     gcode;

    amgr_lane_flags_t    lane_flags [NUM_LANES];
    amgr_match_t         match;
    amgr_result_t        result;
    amgr_result_t        out_result;

    assign ref_base        = s_tdata[OFS_REF_BASE +: BASE_W];
    assign ref_is_single   = s_tdata[OFS_REF_SINGLE];
    assign alt_bases       = s_tdata[OFS_ALT_BASES +: BASE_W*SLOTS_MAX];
    assign alt_single_mask = s_tdata[OFS_ALT_MASK +: SLOTS_MAX];
    assign expected_ref    = s_tdata[OFS_EXP_REF +: BASE_W];
    assign expected_alt    = s_tdata[OFS_EXP_ALT +: BASE_W];
    assign genotype_char   = s_tdata[OFS_GT_CHAR +: BASE_W];

    assign in_fire = s_tvalid && s_tready;

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        amgr_lane u_lane (
            .alt_base     (alt_bases[k*BASE_W +: BASE_W]),
            .alt_single   (alt_single_mask[k]),
            .expected_ref (expected_ref),
            .expected_alt (expected_alt),
            .flags        (lane_flags[k])
        );
    end

    amgr_merge u_merge (
        .prophage_mode (prophage_mode_reg),
        .ref_base      (ref_base),
        .ref_is_single (ref_is_single),
        .expected_ref  (expected_ref),
        .expected_alt  (expected_alt),
        .lane_flags    (lane_flags),
        .match         (match)
    );

    assign gt_num = genotype_char - CHAR_ZERO;

    always_comb
    begin
        if (!held_usable_reg || (genotype_char < CHAR_ZERO))
            gcode = GT_MISSING;
        else if (gt_num == {{(BASE_W-IDX_W){1'b0}}, held_alt_reg})
            gcode = GT_ALT;
        else if (gt_num == {{(BASE_W-IDX_W){1'b0}}, held_ref_reg})
            gcode = GT_REF;
        else
            gcode = GT_MISSING;
    end

    always_comb
    begin
        held_usable_next = held_usable_reg;
        held_ref_next    = held_ref_reg;
        held_alt_next    = held_alt_reg;
        if (in_fire && (s_tuser == CMD_VARIANT))
        begin
            held_usable_next = match.usable;
            held_ref_next    = match.ref_idx;
            held_alt_next    = match.alt_idx;
        end
    end

    always_comb
    begin
        result.kind    = s_tuser;
        result.usable  = held_usable_next;
        result.ref_idx = held_ref_next;
        result.alt_idx = held_alt_next;
        result.gcode   = (s_tuser == CMD_SAMPLE) ? gcode : GT_REF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prophage_mode_reg <= 1'b0;
            held_usable_reg   <= 1'b0;
            held_ref_reg      <= '0;
            held_alt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                prophage_mode_reg <= cfg_wdata;
            held_usable_reg <= held_usable_next;
            held_ref_reg    <= held_ref_next;
            held_alt_reg    <= held_alt_next;
        end
    end

    amgr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_result  (result),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_ready  (m_tready)
    );

    assign m_tuser = out_result.kind;
    assign m_tdata = {{(M_TDATA_W - 2*IDX_W - 1 - GT_W){1'b0}}, out_result.gcode,
                      out_result.usable, out_result.alt_idx, out_result.ref_idx};

    `AMGR_ASSERT_ALWAYS(a_unusable_zero_idx, !held_usable_reg |-> (held_ref_reg == '0 && held_alt_reg == '0), "indices set without usable variant")
    `AMGR_ASSERT(a_usable_distinct, held_usable_reg |-> (held_ref_reg != held_alt_reg), "ref and alt share an allele index")
    `AMGR_ASSERT(a_sample_keeps_held, (in_fire && s_tuser == CMD_SAMPLE) |=> $stable(held_usable_reg) && $stable(held_ref_reg) && $stable(held_alt_reg), "sample item changed held variant")

endmodule

`default_nettype wire

### verif/allele_match_genotype_recoder_top_tb.sv
`timescale 1ns / 1ps

module allele_match_genotype_recoder_top_tb;
    import amgr_pkg::*;

    localparam int  STALL_LIMIT   = 2000;
    localparam bit  MODE_NORMAL   = 1'b0;
    localparam bit  MODE_PROPHAGE = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [BASE_W-1:0]     gt_char;
        logic [BASE_W-1:0]     want_alt;
        logic [BASE_W-1:0]     want_ref;
        logic [NUM_LANES-1:0]  alt_mask;
        logic [4*BASE_W-1:0]   alts;
        logic                  ref_one;
        logic [BASE_W-1:0]     ref_base;
    } locus_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // predicted block state
    bit                   strict_mode = MODE_NORMAL;
    logic [IDX_W-1:0]     call_ref_idx = '0;
    logic [IDX_W-1:0]     call_alt_idx = '0;
    logic                 call_usable = 1'b0;

    amgr_result_t         expected_calls[$];
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   mismatches = 0;
    int                   stall_cycles = 0;
    int                   n_variants = 0;
    int                   n_usable = 0;
    int                   n_samples = 0;
    int                   n_code[4] = '{0, 0, 0, 0};
    int                   n_checked = 0;

    allele_match_genotype_recoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [BASE_W-1:0] strand_partner(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] p;
        p = b;
        if (b == BASE_A)
            p = BASE_T;
        else if (b == BASE_T)
            p = BASE_A;
        else if (b == BASE_C)
            p = BASE_G;
        else if (b == BASE_G)
            p = BASE_C;
        return p;
    endfunction

    function automatic bit is_nucleotide(input logic [BASE_W-1:0] b);
        return b == BASE_A || b == BASE_C || b == BASE_G || b == BASE_T;
    endfunction

    // updates the held call and returns the result the item should produce
    function automatic amgr_result_t recode_locus(input locus_item_t it);
        amgr_result_t      r;
        int                ri;
        int                ai;
        logic [BASE_W-1:0] a;
        logic [BASE_W-1:0] fref;
        logic [BASE_W-1:0] n;
        bit                flip;
        r = '0;
        r.kind = it.cmd;
        if (it.cmd == CMD_VARIANT)
        begin
            ri = -1;
            ai = -1;
            if (it.ref_one)
            begin
                if (strict_mode == MODE_PROPHAGE)
                begin
                    if (it.ref_base == it.want_ref)
                    begin
                        ri = 0;
                        for (int k = 0; k < NUM_LANES; k++)
                        begin
                            a = it.alts[8*k +: 8];
                            if (ai < 0 && it.alt_mask[k] && is_nucleotide(a))
                                ai = k + 1;
                        end
                    end
                end
                else
                begin
                    fref = strand_partner(it.ref_base);
                    flip = (fref == it.want_ref) || (fref == it.want_alt);
                    if (it.ref_base == it.want_ref || fref == it.want_ref)
                        ri = 0;
                    else if (it.ref_base == it.want_alt || fref == it.want_alt)
                        ai = 0;
                    if (ri >= 0 || ai >= 0)
                    begin
                        for (int k = 0; k < NUM_LANES; k++)
                        begin
                            if (it.alt_mask[k])
                            begin
                                a = it.alts[8*k +: 8];
                                if (flip)
                                    a = strand_partner(a);
                                if (a == it.want_ref && ri < 0)
                                    ri = k + 1;
                                else if (a == it.want_alt && ai < 0)
                                    ai = k + 1;
                            end
                        end
                    end
                end
            end
            call_usable  = (ri >= 0 && ai >= 0);
            call_ref_idx = call_usable ? IDX_W'(ri) : '0;
            call_alt_idx = call_usable ? IDX_W'(ai) : '0;
        end
        else
        begin
            n = it.gt_char - CHAR_ZERO;
            if (!call_usable || it.gt_char < CHAR_ZERO)
                r.gcode = GT_MISSING;
            else if (n == {5'b0, call_alt_idx})
                r.gcode = GT_ALT;
            else if (n == {5'b0, call_ref_idx})
                r.gcode = GT_REF;
            else
                r.gcode = GT_MISSING;
        end
        r.ref_idx = call_ref_idx;
        r.alt_idx = call_alt_idx;
        r.usable  = call_usable;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        amgr_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_calls.size() == 0)
                report_mismatch("result with nothing pending", int'(m_tdata), 0);
            else
            begin
                e = expected_calls.pop_front();
                n_checked++;
                if (m_tuser !== e.kind)
                    report_mismatch("result_kind", int'(m_tuser), int'(e.kind));
                if (m_tdata[2:0] !== e.ref_idx)
                    report_mismatch("ref_allele_index", int'(m_tdata[2:0]), int'(e.ref_idx));
                if (m_tdata[5:3] !== e.alt_idx)
                    report_mismatch("alt_allele_index", int'(m_tdata[5:3]), int'(e.alt_idx));
                if (m_tdata[6] !== e.usable)
                    report_mismatch("usable", int'(m_tdata[6]), int'(e.usable));
                if (m_tdata[8:7] !== e.gcode)
                    report_mismatch("genotype_code", int'(m_tdata[8:7]), int'(e.gcode));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d items still pending", expected_calls.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input locus_item_t it);
        amgr_result_t e;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {{(S_TDATA_W - S_USED_W){1'b0}}, it.gt_char, it.want_alt, it.want_ref,
                     it.alt_mask, it.alts, it.ref_one, it.ref_base};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e = recode_locus(it);
        expected_calls.insert(expected_calls.size(), e);
        if (it.cmd == CMD_VARIANT)
        begin
            n_variants++;
            if (e.usable)
                n_usable++;
        end
        else
        begin
            n_samples++;
            n_code[e.gcode]++;
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_calls.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_mode(input bit mode);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        strict_mode = mode;
    endtask

    function automatic locus_item_t make_variant(input logic [7:0] rb, input logic one,
                                                 input logic [31:0] alts, input logic [3:0] mask,
                                                 input logic [7:0] er, input logic [7:0] ea);
        locus_item_t it;
        it.cmd      = CMD_VARIANT;
        it.ref_base = rb;
        it.ref_one  = one;
        it.alts     = alts;
        it.alt_mask = mask;
        it.want_ref = er;
        it.want_alt = ea;
        it.gt_char  = 8'($urandom);
        return it;
    endfunction

    function automatic locus_item_t make_sample(input logic [7:0] g);
        locus_item_t it;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(locus_item_t)-1:0];
        it.cmd     = CMD_SAMPLE;
        it.gt_char = g;
        return it;
    endfunction

    function automatic logic [7:0] pick_base();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1:    b = BASE_A;
            2, 3:    b = BASE_C;
            4, 5:    b = BASE_G;
            6, 7:    b = BASE_T;
            8:       b = 8'h4E;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    task automatic test_normal_matching();
        send_item(make_sample(CHAR_ZERO));                               // no variant yet
        send_item(make_variant(BASE_A, 1'b1, {24'h0, BASE_G}, 4'b0001, BASE_A, BASE_G));
        send_item(make_sample(CHAR_ZERO));
        send_item(make_sample(CHAR_ZERO + 8'd1));
        send_item(make_sample(CHAR_ZERO + 8'd2));
        send_item(make_sample(8'h2F));                                   // below '0'
        send_item(make_sample(8'hFF));
        send_item(make_sample(8'h00));
        // strand flip of REF and ALT
        send_item(make_variant(BASE_T, 1'b1, {24'h0, BASE_G}, 4'b0001, BASE_A, BASE_C));
        send_item(make_sample(CHAR_ZERO + 8'd1));
        // REF is the expected alternate, reference found among ALTs
        send_item(make_variant(BASE_G, 1'b1, {BASE_C, BASE_A, BASE_T, BASE_T}, 4'b1110,
                               BASE_A, BASE_G));
        send_item(make_sample(CHAR_ZERO + 8'd3));
        send_item(make_sample(CHAR_ZERO));
        send_item(make_variant(BASE_A, 1'b0, {24'h0, BASE_G}, 4'b0001, BASE_A, BASE_G));
        send_item(make_variant(BASE_A, 1'b1, {24'h0, BASE_G}, 4'b0000, BASE_A, BASE_G));
        // non-ACGT bases complement to themselves
        send_item(make_variant(8'h4E, 1'b1, {8'h58, 24'h0}, 4'b1000, 8'h4E, 8'h58));
        send_item(make_sample(CHAR_ZERO + 8'd4));
        send_item(make_variant(8'hFF, 1'b1, 32'hFFFF_FFFF, 4'hF, 8'hFF, 8'h00));
        send_item(make_variant(8'h00, 1'b1, 32'h0, 4'h0, 8'h00, 8'h00));
        send_item(make_variant(8'h00, 1'b1, 32'h0, 4'hF, 8'h00, 8'hFF));
    endtask

    task automatic test_prophage_matching();
        send_item(make_variant(BASE_A, 1'b1, {BASE_T, BASE_C, 8'h67, 8'h4E}, 4'b0111,
                               BASE_A, BASE_G));
        send_item(make_sample(CHAR_ZERO + 8'd3));
        send_item(make_sample(CHAR_ZERO));
        send_item(make_variant(BASE_T, 1'b1, {24'h0, BASE_G}, 4'b0001, BASE_A, BASE_G));
        send_item(make_variant(BASE_A, 1'b1, {8'h4E, 8'h4E, 8'h4E, 8'h4E}, 4'hF,
                               BASE_A, BASE_G));
        send_item(make_sample(CHAR_ZERO));
    endtask

    task automatic test_random_records(input int n_items);
        int          sent;
        int          n_gt;
        locus_item_t it;
        logic [95:0] noise;
        logic [7:0]  g;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise = {$urandom, $urandom, $urandom};
                it = noise[$bits(locus_item_t)-1:0];
                send_item(it);
                sent++;
            end
            else
            begin
                send_item(make_variant(pick_base(), $urandom_range(0, 15) != 0,
                                       {pick_base(), pick_base(), pick_base(), pick_base()},
                                       4'($urandom | $urandom), pick_base(), pick_base()));
                sent++;
                n_gt = $urandom_range(0, 6);
                for (int i = 0; i < n_gt; i++)
                begin
                    case ($urandom_range(0, 9))
                        0:       g = 8'h00;
                        1:       g = 8'($urandom);
                        default: g = CHAR_ZERO + 8'($urandom_range(0, 5));
                    endcase
                    send_item(make_sample(g));
                    sent++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 33;
        rx_idle_pct = 88;
        test_normal_matching();
        set_mode(MODE_PROPHAGE);
        test_prophage_matching();
        set_mode(MODE_NORMAL);
        test_random_records(150);

        tx_idle_pct = 88;
        rx_idle_pct = 33;
        set_mode(MODE_PROPHAGE);
        test_random_records(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_mode(MODE_NORMAL);
        test_random_records(75);
        set_mode(MODE_PROPHAGE);
        test_random_records(75);

        wait_for_results();
        $display("covered %0d variant items (%0d usable) and %0d genotype items, both modes",
                 n_variants, n_usable, n_samples);
        $display("genotype codes ref/alt/missing: %0d/%0d/%0d, %0d results checked",
                 n_code[GT_REF], n_code[GT_ALT], n_code[GT_MISSING], n_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
